// File: sv/dda_pkg.sv
package dda_pkg;

  localparam int CREDIT_W  = 18;
  localparam int REACHED_W = 17;
  localparam int DENS_W    = 8;
  localparam int SHIFT_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [REACHED_W-1:0] REACHED_MAX = 17'h1FFFF;
  localparam logic [CREDIT_W-1:0]  CREDIT_MAX  = 18'h3FFFF;

  typedef enum logic [1:0] {
    OP_PLOT = 2'd0,
    OP_END  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    KIND_READ   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_CAP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_SHIFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_QUOTA      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_THRESHOLD = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOT_WR,
    ST_READ_OUT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SWEEP_INIT,
    ST_SWEEP
  } state_t;

  // One fade of a density count: c - ((c >> sh) + 1), floored at zero.
  function automatic logic [DENS_W-1:0] fade_step(input logic [DENS_W-1:0] c,
                                                  input logic [SHIFT_W-1:0] sh);
    logic [DENS_W:0] take;
    take = {1'b0, c >> sh} + 9'd1;
    fade_step = ({1'b0, c} > take) ? DENS_W'({1'b0, c} - take) : '0;
  endfunction

endpackage

// File: sv/dda_div.sv
module dda_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dda_pkg::CREDIT_W-1:0]  dividend,
  input  logic [dda_pkg::CREDIT_W-1:0]  divisor,
  output logic                          done,
  output logic [dda_pkg::CREDIT_W-1:0]  quotient,
  output logic [dda_pkg::CREDIT_W-1:0]  remainder
);
  import dda_pkg::*;

  localparam int CNT_W = $clog2(CREDIT_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CREDIT_W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CREDIT_W-1:0] rem_r, rem_nxt;
  logic [CREDIT_W-1:0] quo_r, quo_nxt;
  logic [CREDIT_W-1:0] div_r, div_nxt;
  logic [CREDIT_W:0]   trial;
  logic                fits;

  // Restoring division, one quotient bit a cycle; quo_r shifts the dividend out
  // at the top while the quotient bits enter at the bottom.
  assign trial = {rem_r, quo_r[CREDIT_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? CREDIT_W'(trial - {1'b0, div_r}) : CREDIT_W'(trial);
      quo_nxt = {quo_r[CREDIT_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: sv/decaying_density_accumulator.sv
// Decaying pixel density store.
// Input beats: in_tuser carries the opcode (plot, end of step, read), in_tdata
// the signed pixel coordinates. Plot beats give no result; read and end-of-step
// beats each give one output beat, out_tuser telling which kind it is.
// Plot: the density and hit memories are read, then written back in ST_PLOT_WR.
// Read: the memories are read, then the reply is loaded into the output register once free.
// End of step: ST_DIV_START, the credit / quota divider (skipped with a zero
// quota) and ST_SWEEP_INIT come before the sweep, then max(passes,1) back-to-back
// sweeps of all SCREEN_WIDTH*SCREEN_HEIGHT pixels (passes = fade count, capped at
// 256), limited by the single read port of the memories; the last write-back then
// finishes and the report is loaded. The sweep also clears the per-step hit counts.
// Reset: a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT pixels zeroes both
// memories; in_tready stays low meanwhile, configuration writes are taken.
// Output stall: a waiting result sits in the output register while plots keep
// being accepted; a new result waits for the register before the block frees.
// cfg_* writes one register per cycle; write only while the block is idle.
module decaying_density_accumulator #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // x_pixel[10:0], y_pixel[21:11]
  input  logic [1:0]                      in_tuser,   // opcode[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // density_value[7:0], reached_count[24:8], stalled_flag[25], fades_done[33:26]
  output logic [39:0]                     out_tdata,
  output logic [0:0]                      out_tuser,  // result_kind[0]
  input  logic                            cfg_we,
  input  logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dda_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dda_pkg::*;

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
  localparam logic [11:0] WIDTH_12  = 12'(SCREEN_WIDTH);
  localparam logic [11:0] HEIGHT_12 = 12'(SCREEN_HEIGHT);

  // configuration
  logic [DENS_W-1:0]    limit_r, cap_r;
  logic [SHIFT_W-1:0]   shift_r;
  logic [CREDIT_W-1:0]  quota_r;
  logic [REACHED_W-1:0] stall_thr_r;

  state_t state_r, state_nxt;

  logic [REACHED_W-1:0] reached_r, reached_nxt;
  logic [CREDIT_W-1:0]  credit_r, credit_nxt;
  logic [CREDIT_W-1:0]  fades_r, fades_nxt;
  logic [ADDR_W-1:0]    plot_idx_r, plot_idx_nxt;
  logic                 read_on_r, read_on_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]    sw_rd_addr_r, sw_rd_addr_nxt;
  logic [ADDR_W-1:0]    sw_wr_addr_r, sw_wr_addr_nxt;
  logic                 sw_rd_active_r, sw_rd_active_nxt;
  logic                 sw_pend_r, sw_pend_nxt;
  logic [8:0]           pass_left_r, pass_left_nxt;
  logic                 fade_en_r, fade_en_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [39:0]          out_data_r, out_data_nxt;
  logic [0:0]           out_kind_r, out_kind_nxt;

  // memories
  logic [DENS_W-1:0] dens_mem [PIXELS];
  logic [DENS_W-1:0] hits_mem [PIXELS];
  logic [DENS_W-1:0] dens_rd_r, hits_rd_r;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              dens_we, hits_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DENS_W-1:0] dens_wdata, hits_wdata;

  // input decode
  logic              in_fire;
  op_t               in_op;
  logic [10:0]       in_x, in_y;
  logic              in_on;
  logic [20:0]       idx_full;
  logic [ADDR_W-1:0] in_idx;
  logic              out_free;

  // divider
  logic                div_start, div_done;
  logic [CREDIT_W-1:0] div_quo, div_rem;

  logic [CREDIT_W:0]   credit_sum;
  logic [8:0]          passes;
  logic [DENS_W-1:0]   fades_sat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_op     = op_t'(in_tuser);
  assign in_x      = in_tdata[10:0];
  assign in_y      = in_tdata[21:11];
  assign in_on     = !in_x[10] && !in_y[10] &&
                     ({1'b0, in_x} < WIDTH_12) && ({1'b0, in_y} < HEIGHT_12);
  assign idx_full  = 21'(in_y[9:0]) * 21'(SCREEN_WIDTH) + 21'(in_x[9:0]);
  assign in_idx    = idx_full[ADDR_W-1:0];
  assign out_free  = !out_valid_r || out_tready;

  assign credit_sum = {1'b0, credit_r} + (CREDIT_W+1)'(reached_r);
  assign passes     = (fades_r > 18'd256) ? 9'd256 : fades_r[8:0];
  assign fades_sat  = (fades_r > 18'd255) ? 8'd255 : fades_r[7:0];

  dda_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (credit_r),
    .divisor   (quota_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:      if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_PLOT: if (in_on) state_nxt = ST_PLOT_WR;
            OP_END:  state_nxt = ST_DIV_START;
            OP_READ: state_nxt = ST_READ_OUT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PLOT_WR:    state_nxt = ST_IDLE;
      ST_READ_OUT:   if (out_free) state_nxt = ST_IDLE;
      ST_DIV_START:  state_nxt = (quota_r == '0) ? ST_SWEEP_INIT : ST_DIV_WAIT;
      ST_DIV_WAIT:   if (div_done) state_nxt = ST_SWEEP_INIT;
      ST_SWEEP_INIT: state_nxt = ST_SWEEP;
      ST_SWEEP:      if (!sw_rd_active_r && !sw_pend_r && out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    reached_nxt      = reached_r;
    credit_nxt       = credit_r;
    fades_nxt        = fades_r;
    plot_idx_nxt     = plot_idx_r;
    read_on_nxt      = read_on_r;
    clr_addr_nxt     = clr_addr_r;
    sw_rd_addr_nxt   = sw_rd_addr_r;
    sw_wr_addr_nxt   = sw_wr_addr_r;
    sw_rd_active_nxt = sw_rd_active_r;
    sw_pend_nxt      = 1'b0;
    pass_left_nxt    = pass_left_r;
    fade_en_nxt      = fade_en_r;
    out_valid_nxt    = out_valid_r & ~out_tready;
    out_data_nxt     = out_data_r;
    out_kind_nxt     = out_kind_r;
    div_start        = 1'b0;
    mem_re           = 1'b0;
    mem_raddr        = in_idx;
    dens_we          = 1'b0;
    hits_we          = 1'b0;
    mem_waddr        = plot_idx_r;
    dens_wdata       = dens_rd_r;
    hits_wdata       = hits_rd_r;

    case (state_r)
      ST_CLEAR: begin
        dens_we      = 1'b1;
        hits_we      = 1'b1;
        mem_waddr    = clr_addr_r;
        dens_wdata   = '0;
        hits_wdata   = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          plot_idx_nxt = in_idx;
          read_on_nxt  = in_on;
          mem_re       = in_on && (in_op == OP_PLOT || in_op == OP_READ);
          if (in_op == OP_END) begin
            credit_nxt = (credit_sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX
                                                           : credit_sum[CREDIT_W-1:0];
          end
        end
      end
      ST_PLOT_WR: begin
        dens_we = 1'b1;
        hits_we = 1'b1;
        if (hits_rd_r == '0 && reached_r < REACHED_MAX) reached_nxt = reached_r + 1'b1;
        if (hits_rd_r < cap_r) begin
          hits_wdata = hits_rd_r + 1'b1;
          if (dens_rd_r < limit_r) dens_wdata = dens_rd_r + 1'b1;
        end
      end
      ST_READ_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {32'd0, read_on_r ? dens_rd_r : 8'd0};
          out_kind_nxt  = KIND_READ;
        end
      end
      ST_DIV_START: begin
        fades_nxt = '0;
        div_start = (quota_r != '0);
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          fades_nxt  = div_quo;
          credit_nxt = div_rem;
        end
      end
      ST_SWEEP_INIT: begin
        // a step with no fade still sweeps once to clear the hit counts
        pass_left_nxt    = (passes == '0) ? 9'd1 : passes;
        fade_en_nxt      = (passes != '0);
        sw_rd_addr_nxt   = '0;
        sw_rd_active_nxt = 1'b1;
      end
      ST_SWEEP: begin
        mem_raddr = sw_rd_addr_r;
        if (sw_rd_active_r) begin
          mem_re         = 1'b1;
          sw_pend_nxt    = 1'b1;
          sw_wr_addr_nxt = sw_rd_addr_r;
          if (sw_rd_addr_r == LAST_ADDR) begin
            sw_rd_addr_nxt = '0;
            if (pass_left_r == 9'd1) sw_rd_active_nxt = 1'b0;
            else pass_left_nxt = pass_left_r - 1'b1;
          end else begin
            sw_rd_addr_nxt = sw_rd_addr_r + 1'b1;
          end
        end
        if (sw_pend_r) begin
          dens_we    = 1'b1;
          hits_we    = 1'b1;
          mem_waddr  = sw_wr_addr_r;
          dens_wdata = fade_en_r ? fade_step(dens_rd_r, shift_r) : dens_rd_r;
          hits_wdata = '0;
        end
        if (!sw_rd_active_r && !sw_pend_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, fades_sat, reached_r < stall_thr_r, reached_r, 8'd0};
          out_kind_nxt  = KIND_REPORT;
          reached_nxt   = '0;
        end
      end
      default: begin
        clr_addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dens_we) dens_mem[mem_waddr] <= dens_wdata;
    if (mem_re)  dens_rd_r <= dens_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (hits_we) hits_mem[mem_waddr] <= hits_wdata;
    if (mem_re)  hits_rd_r <= hits_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      reached_r      <= '0;
      credit_r       <= '0;
      sw_rd_active_r <= 1'b0;
      sw_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      limit_r        <= 8'd255;
      cap_r          <= 8'd16;
      shift_r        <= 3'd3;
      quota_r        <= 18'd18724;
      stall_thr_r    <= 17'd1170;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      reached_r      <= reached_nxt;
      credit_r       <= credit_nxt;
      sw_rd_active_r <= sw_rd_active_nxt;
      sw_pend_r      <= sw_pend_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DENSITY_LIMIT:   limit_r     <= cfg_wdata[DENS_W-1:0];
          REG_STEP_CAP:        cap_r       <= cfg_wdata[DENS_W-1:0];
          REG_FADE_SHIFT:      shift_r     <= cfg_wdata[SHIFT_W-1:0];
          REG_FADE_QUOTA:      quota_r     <= cfg_wdata[CREDIT_W-1:0];
          REG_STALL_THRESHOLD: stall_thr_r <= cfg_wdata[REACHED_W-1:0];
          default: ;
        endcase
      end
    end
    fades_r      <= fades_nxt;
    plot_idx_r   <= plot_idx_nxt;
    read_on_r    <= read_on_nxt;
    sw_rd_addr_r <= sw_rd_addr_nxt;
    sw_wr_addr_r <= sw_wr_addr_nxt;
    pass_left_r  <= pass_left_nxt;
    fade_en_r    <= fade_en_nxt;
    out_data_r   <= out_data_nxt;
    out_kind_r   <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

// File: dv/decaying_density_checker.sv
`timescale 1ns / 100ps

module decaying_density_checker #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // x_pixel[10:0], y_pixel[21:11]
  input  logic [1:0]                     in_tuser,   // opcode[1:0]
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // density_value[7:0], reached_count[24:8], stalled_flag[25], fades_done[33:26]
  input  logic [39:0]                    out_tdata,
  input  logic [0:0]                     out_tuser,  // result_kind[0]
  input  logic                           cfg_we,
  input  logic [dda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dda_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             pending
);
  import dda_pkg::*;

  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    kind_t                kind;
    logic [DENS_W-1:0]    density;
    logic [REACHED_W-1:0] reached;
    logic                 stalled;
    logic [7:0]           fades;
  } reply_t;

  logic [DENS_W-1:0] density_map [PIXELS];
  logic [7:0]        hit_map [PIXELS];
  int unsigned       reached_pixels;
  int unsigned       drawn_credit;

  logic [7:0]           limit_cfg;
  logic [7:0]           cap_cfg;
  logic [SHIFT_W-1:0]   shift_cfg;
  logic [CREDIT_W-1:0]  quota_cfg;
  logic [REACHED_W-1:0] thresh_cfg;

  reply_t awaited_replies [$];
  reply_t want;
  int     error_count;

  function automatic bit pixel_index(input logic [21:0] coords, output int idx);
    logic signed [10:0] px;
    logic signed [10:0] py;
    px = coords[10:0];
    py = coords[21:11];
    idx = int'(py) * SCREEN_WIDTH + int'(px);
    return px >= 0 && py >= 0 && px < SCREEN_WIDTH && py < SCREEN_HEIGHT;
  endfunction

  task automatic absorb_beat(input op_t op, input logic [21:0] coords);
    int          idx;
    bit          on_screen;
    int unsigned fades;
    int unsigned passes;
    int unsigned take;
    reply_t      r;
    on_screen = pixel_index(coords, idx);
    r = '0;
    r.kind = KIND_READ;
    case (op)
      OP_PLOT: begin
        if (on_screen) begin
          if (hit_map[idx] == 0 && reached_pixels < REACHED_MAX)
            reached_pixels++;
          if (hit_map[idx] < cap_cfg) begin
            hit_map[idx]++;
            if (density_map[idx] < limit_cfg)
              density_map[idx]++;
          end
        end
      end
      OP_END: begin
        drawn_credit += reached_pixels;
        if (drawn_credit > CREDIT_MAX)
          drawn_credit = CREDIT_MAX;
        fades = 0;
        // zero quota: no fading, credit kept
        if (quota_cfg != 0) begin
          fades = drawn_credit / quota_cfg;
          drawn_credit -= fades * quota_cfg;
        end
        passes = (fades > 256) ? 256 : fades;
        for (int p = 0; p < passes; p++) begin
          for (int i = 0; i < PIXELS; i++) begin
            take = (density_map[i] >> shift_cfg) + 1;
            density_map[i] = (density_map[i] > take) ? DENS_W'(density_map[i] - take) : '0;
          end
        end
        r.kind    = KIND_REPORT;
        r.reached = REACHED_W'(reached_pixels);
        r.stalled = reached_pixels < thresh_cfg;
        r.fades   = (fades > 255) ? 8'd255 : 8'(fades);
        awaited_replies.push_back(r);
        for (int i = 0; i < PIXELS; i++)
          hit_map[i] = '0;
        reached_pixels = 0;
      end
      OP_READ: begin
        r.density = on_screen ? density_map[idx] : '0;
        awaited_replies.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIXELS; i++) begin
        density_map[i] = '0;
        hit_map[i] = '0;
      end
      reached_pixels = 0;
      drawn_credit = 0;
      limit_cfg = 8'd255;
      cap_cfg = 8'd16;
      shift_cfg = 3'd3;
      quota_cfg = 18'd18724;
      thresh_cfg = 17'd1170;
      awaited_replies.delete();
      error_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DENSITY_LIMIT:   limit_cfg = cfg_wdata[7:0];
          REG_STEP_CAP:        cap_cfg = cfg_wdata[7:0];
          REG_FADE_SHIFT:      shift_cfg = cfg_wdata[SHIFT_W-1:0];
          REG_FADE_QUOTA:      quota_cfg = cfg_wdata[CREDIT_W-1:0];
          REG_STALL_THRESHOLD: thresh_cfg = cfg_wdata[REACHED_W-1:0];
          default: ;
        endcase
      end
      // retire the output beat first so a beat accepted on the same edge
      // can never be matched against its own reply
      if (out_tvalid && out_tready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got kind %0d tdata %h",
                   $time, out_tuser, out_tdata);
          error_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_tuser !== want.kind || out_tdata[7:0] !== want.density ||
              out_tdata[24:8] !== want.reached || out_tdata[25] !== want.stalled ||
              out_tdata[33:26] !== want.fades) begin
            // kind/density/reached/stalled/fades
            $display("%0t: mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                     $time, want.kind, want.density, want.reached, want.stalled,
                     want.fades, out_tuser, out_tdata[7:0], out_tdata[24:8],
                     out_tdata[25], out_tdata[33:26]);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        absorb_beat(op_t'(in_tuser), in_tdata[21:0]);
    end
    mismatches <= error_count;
    pending <= awaited_replies.size();
  end

endmodule

// File: dv/decaying_density_accumulator_test.sv
`timescale 1ns / 100ps

module decaying_density_accumulator_test;
  import dda_pkg::*;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  // reset clear plus about twenty sweeps of the 64K-pixel screen, several times over
  localparam int CYCLE_LIMIT   = 6000000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_BEATS   = 225;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // x_pixel[10:0], y_pixel[21:11]
  logic [1:0]            in_tuser;   // opcode[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  // density_value[7:0], reached_count[24:8], stalled_flag[25], fades_done[33:26]
  logic [39:0]           out_tdata;
  logic [0:0]            out_tuser;  // result_kind[0]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  bit hold_long = 1'b0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  decaying_density_accumulator #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  decaying_density_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("decaying_density_accumulator_test NOT OK");
    $finish;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input op_t op, input int x, input int y);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, 11'(y), 11'(x)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_settings(input int limit, input int cap, input int shift,
                                input int quota, input int thresh);
    logic [CFG_IDX_W-1:0] reg_ids [5];
    int vals [5];
    reg_ids = '{REG_DENSITY_LIMIT, REG_STEP_CAP, REG_FADE_SHIFT, REG_FADE_QUOTA,
                REG_STALL_THRESHOLD};
    vals = '{limit, cap, shift, quota, thresh};
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_ids[k];
      cfg_wdata <= CFG_DATA_W'(vals[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    // pending is registered, so it trails the accepted beat
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_point(output int x, output int y);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      // small window: many repeat hits, cap and limit get exercised
      x = $urandom_range(0, 15);
      y = $urandom_range(0, 15);
    end else if (sel < 85) begin
      x = $urandom_range(0, SCREEN_WIDTH - 1);
      y = $urandom_range(0, SCREEN_HEIGHT - 1);
    end else begin
      x = int'($urandom_range(0, 2047)) - 1024;
      y = int'($urandom_range(0, 2047)) - 1024;
    end
  endtask

  // receiver
  initial begin
    int n;
    int gap;
    n = 0;
    forever begin
      if (n % 64 == 0) calm_out = ($urandom_range(0, 3) == 0);
      n++;
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        gap = pick_gap(calm_out);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // sender
  initial begin
    int   r;
    int   x;
    int   y;
    int   step_plots;
    int   step_len;
    op_t  op;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_PLOT;
    cfg_we <= 1'b0;
    cfg_index <= REG_DENSITY_LIMIT;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // cap of 3 on a pixel hit four times, off-screen points, ignored opcode
    write_settings(255, 3, 0, 131072, 0);
    repeat (4) send_beat(OP_PLOT, 0, 0);
    send_beat(OP_PLOT, 255, 255);
    send_beat(OP_PLOT, -1, 0);
    send_beat(OP_PLOT, 256, 5);
    send_beat(OP_PLOT, 5, 256);
    send_beat(OP_PLOT, -1024, -1024);
    send_beat(OP_PLOT, 1023, 1023);
    send_beat(OP_NONE, 0, 0);
    send_beat(OP_READ, 0, 0);
    send_beat(OP_READ, 255, 255);
    send_beat(OP_READ, -1, -1);
    send_beat(OP_END, 0, 0);
    drain_replies();

    // limit lowered below a stored count; tiny quota gives two fades
    write_settings(2, 255, 7, 2, 65536);
    send_beat(OP_PLOT, 0, 0);
    repeat (3) send_beat(OP_PLOT, 1, 0);
    send_beat(OP_READ, 0, 0);
    send_beat(OP_END, 0, 0);
    send_beat(OP_READ, 0, 0);
    drain_replies();

    // zero quota keeps the credit
    write_settings(128, 16, 3, 0, 1170);
    repeat (2) send_beat(OP_PLOT, 10, 10);
    send_beat(OP_END, 0, 0);
    drain_replies();

    // steps stay shorter than the smallest quota, so at most a few fades each
    step_plots = 0;
    step_len = $urandom_range(60, 140);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_settings(1, 1, 0, $urandom_range(256, 1024), 0);
        3: write_settings(255, 255, 7, 131072, 65536);
        default: write_settings($urandom_range(1, 255),
                                $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 255),
                                $urandom_range(0, 7), $urandom_range(256, 1024),
                                $urandom_range(0, 150));
      endcase
      if (ph == 1) hold_long = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n % 32 == 0) calm_in = ($urandom_range(0, 3) == 0);
        if (step_plots >= step_len) begin
          send_beat(OP_END, $urandom_range(0, 2047), $urandom_range(0, 2047));
          step_plots = 0;
          step_len = $urandom_range(60, 140);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) op = OP_PLOT;
          else if (r < 96) op = OP_READ;
          else op = OP_NONE;
          pick_point(x, y);
          send_beat(op, x, y);
          if (op == OP_PLOT) step_plots++;
        end
      end
      drain_replies();
    end

    if (mismatches == 0 && pending == 0)
      $display("decaying_density_accumulator_test OK");
    else
      $display("decaying_density_accumulator_test NOT OK");
    $finish;
  end

endmodule
